// ----- hw/rtl/gwdf_pkg.sv -----
// Shared types, codes and default sizes for the grid wavefront distance fill block.
package gwdf_pkg;

    localparam int MAX_COLS_DEF     = 64;
    localparam int MAX_ROWS_DEF     = 64;
    localparam int WEIGHT_LIMIT_DEF = 4095;

    localparam int GRID_W = 7;
    localparam int REQ_W  = 2;
    localparam int IDX_W  = 6;
    localparam int CODE_W = 2;
    localparam int OUT_W  = 13;

    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd2;
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic [CODE_W-1:0] CODE_EMPTY = 2'd0;
    localparam logic [CODE_W-1:0] CODE_SEED  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_BLOCK = 2'd2;
    localparam logic [CODE_W-1:0] CODE_BAD   = 2'd3;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_PROG  = 2'd1;
    localparam logic [1:0] MODE_ARMED = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_RES,
        S_PASS,
        S_CELL_RD,
        S_CELL_EV,
        S_NB_RD,
        S_NB_EV,
        S_ADV,
        S_PEND,
        S_DONE
    } t_state;

    typedef struct packed {
        logic clr_wr;
        logic accept;
        logic rd_res;
        logic pass_init;
        logic cell_rd;
        logic cell_eval;
        logic nb_rd;
        logic nb_eval;
        logic adv;
        logic pass_end;
        logic done;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic grid_empty;
        logic grow;
        logic nb_in;
        logic nb_last;
        logic scan_end;
        logic empty_seen;
        logic at_limit;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/gwdf_ctrl.sv -----
// Sequencer for requests, the clearing sweep and the fill passes.
module gwdf_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [gwdf_pkg::REQ_W-1:0]   i_req_type,
    input  gwdf_pkg::t_stat              i_stat,
    output gwdf_pkg::t_cmd               o_cmd
);

    gwdf_pkg::t_state r_state;
    gwdf_pkg::t_state n_state;
    logic             in_ok;
    logic             acc;

    assign in_ok   = (r_state == gwdf_pkg::S_IDLE) && i_stat.out_free;
    assign o_stall = !in_ok;
    assign acc     = i_valid && in_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwdf_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            gwdf_pkg::S_CLEAR: begin
                if (i_stat.clr_last) n_state = gwdf_pkg::S_IDLE;
            end
            gwdf_pkg::S_IDLE: begin
                if (acc && i_req_type == gwdf_pkg::REQ_RUN) n_state = gwdf_pkg::S_PASS;
                else if (acc && i_req_type == gwdf_pkg::REQ_READ) n_state = gwdf_pkg::S_RD_RES;
            end
            gwdf_pkg::S_RD_RES: n_state = gwdf_pkg::S_IDLE;
            gwdf_pkg::S_PASS: begin
                n_state = i_stat.grid_empty ? gwdf_pkg::S_PEND : gwdf_pkg::S_CELL_RD;
            end
            gwdf_pkg::S_CELL_RD: n_state = gwdf_pkg::S_CELL_EV;
            gwdf_pkg::S_CELL_EV: begin
                n_state = i_stat.grow ? gwdf_pkg::S_NB_RD : gwdf_pkg::S_ADV;
            end
            gwdf_pkg::S_NB_RD: begin
                if (i_stat.nb_in) n_state = gwdf_pkg::S_NB_EV;
                else if (i_stat.nb_last) n_state = gwdf_pkg::S_ADV;
            end
            gwdf_pkg::S_NB_EV: begin
                n_state = i_stat.nb_last ? gwdf_pkg::S_ADV : gwdf_pkg::S_NB_RD;
            end
            gwdf_pkg::S_ADV: begin
                n_state = i_stat.scan_end ? gwdf_pkg::S_PEND : gwdf_pkg::S_CELL_RD;
            end
            gwdf_pkg::S_PEND: begin
                if (!i_stat.empty_seen || i_stat.at_limit) n_state = gwdf_pkg::S_DONE;
                else n_state = gwdf_pkg::S_PASS;
            end
            gwdf_pkg::S_DONE: n_state = gwdf_pkg::S_IDLE;
            default: n_state = gwdf_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            gwdf_pkg::S_CLEAR:   o_cmd.clr_wr    = 1'b1;
            gwdf_pkg::S_IDLE:    o_cmd.accept    = acc;
            gwdf_pkg::S_RD_RES:  o_cmd.rd_res    = 1'b1;
            gwdf_pkg::S_PASS:    o_cmd.pass_init = 1'b1;
            gwdf_pkg::S_CELL_RD: o_cmd.cell_rd   = 1'b1;
            gwdf_pkg::S_CELL_EV: o_cmd.cell_eval = 1'b1;
            gwdf_pkg::S_NB_RD:   o_cmd.nb_rd     = 1'b1;
            gwdf_pkg::S_NB_EV:   o_cmd.nb_eval   = 1'b1;
            gwdf_pkg::S_ADV:     o_cmd.adv       = 1'b1;
            gwdf_pkg::S_PEND:    o_cmd.pass_end  = 1'b1;
            gwdf_pkg::S_DONE:    o_cmd.done      = 1'b1;
            default:             o_cmd           = '0;
        endcase
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != gwdf_pkg::S_IDLE) |-> o_stall)
        else $error("request taken while the sequencer is busy");

    a_rd_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gwdf_pkg::S_RD_RES) |-> ($past(r_state) == gwdf_pkg::S_IDLE))
        else $error("read result without a read request");

    a_nb_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gwdf_pkg::S_NB_EV) |-> ($past(r_state) == gwdf_pkg::S_NB_RD))
        else $error("neighbour check without a neighbour read");

endmodule

// ----- hw/rtl/gwdf_dpath.sv -----
// Cell store, scan counters, pass bookkeeping and result register.
module gwdf_dpath #(
    parameter int MAX_COLS     = gwdf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS     = gwdf_pkg::MAX_ROWS_DEF,
    parameter int WEIGHT_LIMIT = gwdf_pkg::WEIGHT_LIMIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  gwdf_pkg::t_cmd                     i_cmd,
    output gwdf_pkg::t_stat                    o_stat,
    input  logic [gwdf_pkg::REQ_W-1:0]         i_req_type,
    input  logic [gwdf_pkg::IDX_W-1:0]         i_row,
    input  logic [gwdf_pkg::IDX_W-1:0]         i_col,
    input  logic [gwdf_pkg::CODE_W-1:0]        i_cell_code,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [gwdf_pkg::GRID_W-1:0]        i_cfg_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [gwdf_pkg::OUT_W-1:0]  o_cell_value,
    output logic                               o_limit_hit
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;
    localparam int HN    = $clog2(MAX_ROWS + 1);
    localparam int WN    = $clog2(MAX_COLS + 1);
    localparam int PW    = $clog2(WEIGHT_LIMIT + 1);
    localparam int VW    = (PW + 1 > gwdf_pkg::OUT_W) ? PW + 1 : gwdf_pkg::OUT_W;
    localparam int SRW   = RW + 2;
    localparam int SCW   = CW + 2;

    logic [VW-1:0]               r_mem [DEPTH];
    logic [VW-1:0]               r_q;
    logic [gwdf_pkg::GRID_W-1:0] r_gw;
    logic [gwdf_pkg::GRID_W-1:0] r_gh;
    logic [RW-1:0]               r_r;
    logic [CW-1:0]               r_c;
    logic [1:0]                  r_dr;
    logic [1:0]                  r_dc;
    logic [PW-1:0]               r_n;
    logic [1:0]                  r_mode;
    logic                        r_empty;
    logic                        r_prog;
    logic                        r_limit;
    logic [AW-1:0]               r_clr;
    logic                        r_rd_in;
    logic                        r_o_valid;
    logic [gwdf_pkg::OUT_W-1:0]  r_o_val;
    logic                        r_o_lim;

    logic [HN-1:0]         h_eff;
    logic [WN-1:0]         w_eff;
    logic [8:0]            row_x;
    logic [8:0]            col_x;
    logic                  in_inside;
    logic [AW-1:0]         in_addr;
    logic [AW-1:0]         cur_addr;
    logic signed [SRW-1:0] nb_r;
    logic signed [SCW-1:0] nb_c;
    logic                  nb_in;
    logic [AW-1:0]         nb_addr;
    logic                  is_seed;
    logic                  is_block;
    logic                  is_prev;
    logic                  empty_now;
    logic                  row_last;
    logic                  col_last;
    logic                  last_fire;
    logic                  nb_last;
    logic [VW-1:0]         code_val;
    logic [VW-1:0]         n_ext;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [VW-1:0]         wr_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;

    assign h_eff = (int'(r_gh) > MAX_ROWS) ? HN'(MAX_ROWS) : HN'(r_gh);
    assign w_eff = (int'(r_gw) > MAX_COLS) ? WN'(MAX_COLS) : WN'(r_gw);

    assign row_x     = 9'(i_row);
    assign col_x     = 9'(i_col);
    assign in_inside = (int'(i_row) < MAX_ROWS) && (int'(i_col) < MAX_COLS);
    assign in_addr   = {row_x[RW-1:0], col_x[CW-1:0]};
    assign cur_addr  = {r_r, r_c};

    assign nb_r    = $signed(SRW'(r_r)) + $signed(SRW'(r_dr)) - SRW'(1);
    assign nb_c    = $signed(SCW'(r_c)) + $signed(SCW'(r_dc)) - SCW'(1);
    assign nb_in   = (nb_r >= 0) && (nb_r < $signed(SRW'(h_eff)))
                  && (nb_c >= 0) && (nb_c < $signed(SCW'(w_eff)));
    assign nb_addr = {nb_r[RW-1:0], nb_c[CW-1:0]};
    assign nb_last = (r_dr == 2'd2) && (r_dc == 2'd2);

    assign n_ext     = VW'(r_n);
    assign is_seed   = (r_q == VW'(-1));
    assign is_block  = (r_q == VW'(-2));
    assign is_prev   = (r_n > PW'(1)) && (r_q == VW'(r_n - PW'(1)));
    assign empty_now = r_empty || (r_q == '0);

    assign row_last  = ((HN + 1)'(r_r) + (HN + 1)'(1)) == (HN + 1)'(h_eff);
    assign col_last  = ((WN + 1)'(r_c) + (WN + 1)'(1)) == (WN + 1)'(w_eff);
    assign last_fire = row_last && col_last && (r_mode == gwdf_pkg::MODE_ARMED) && r_empty;

    always_comb begin
        case (i_cell_code)
            gwdf_pkg::CODE_SEED:  code_val = VW'(-1);
            gwdf_pkg::CODE_BLOCK: code_val = VW'(-2);
            default:              code_val = '0;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cur_addr;
        wr_data = n_ext;
        if (i_cmd.clr_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
            wr_data = '0;
        end else if (i_cmd.accept && i_req_type == gwdf_pkg::REQ_WRITE && in_inside
                     && i_cell_code != gwdf_pkg::CODE_BAD) begin
            wr_en   = 1'b1;
            wr_addr = in_addr;
            wr_data = code_val;
        end else if (i_cmd.nb_eval && r_q == '0) begin
            wr_en   = 1'b1;
            wr_addr = nb_addr;
        end else if (i_cmd.adv && last_fire) begin
            wr_en   = 1'b1;
        end
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = cur_addr;
        if (i_cmd.accept && i_req_type == gwdf_pkg::REQ_READ && in_inside) begin
            rd_en   = 1'b1;
            rd_addr = in_addr;
        end else if (i_cmd.cell_rd) begin
            rd_en   = 1'b1;
        end else if (i_cmd.nb_rd && nb_in) begin
            rd_en   = 1'b1;
            rd_addr = nb_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_q <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw      <= 7'd64;
            r_gh      <= 7'd64;
            r_n       <= '0;
            r_mode    <= gwdf_pkg::MODE_PROG;
            r_empty   <= 1'b0;
            r_prog    <= 1'b0;
            r_limit   <= 1'b0;
            r_clr     <= '0;
            r_rd_in   <= 1'b0;
            r_o_valid <= 1'b0;
            r_r       <= '0;
            r_c       <= '0;
            r_dr      <= '0;
            r_dc      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == gwdf_pkg::CFG_WIDTH) r_gw <= i_cfg_data;
                else r_gh <= i_cfg_data;
            end
            if (i_cmd.clr_wr) r_clr <= r_clr + AW'(1);

            if (r_o_valid && !i_stall) r_o_valid <= 1'b0;
            if (i_cmd.accept) begin
                r_rd_in <= in_inside;
                if (i_req_type == gwdf_pkg::REQ_RUN) begin
                    r_mode  <= gwdf_pkg::MODE_PROG;
                    r_limit <= 1'b0;
                    r_n     <= PW'(1);
                end else if (i_req_type != gwdf_pkg::REQ_READ) begin
                    r_o_valid <= 1'b1;
                    r_o_val   <= '0;
                    r_o_lim   <= r_limit;
                end
            end
            if (i_cmd.rd_res) begin
                r_o_valid <= 1'b1;
                r_o_val   <= r_rd_in ? r_q[gwdf_pkg::OUT_W-1:0] : '0;
                r_o_lim   <= r_limit;
            end
            if (i_cmd.done) begin
                r_o_valid <= 1'b1;
                r_o_val   <= '0;
                r_o_lim   <= r_limit;
            end

            if (i_cmd.pass_init) begin
                r_mode  <= (r_mode == gwdf_pkg::MODE_IDLE) ? gwdf_pkg::MODE_ARMED
                                                            : gwdf_pkg::MODE_IDLE;
                r_empty <= 1'b0;
                r_r     <= '0;
                r_c     <= '0;
            end
            if (i_cmd.cell_eval) begin
                r_empty <= empty_now;
                r_prog  <= is_seed || is_prev;
                r_dr    <= '0;
                r_dc    <= '0;
            end
            if ((i_cmd.nb_rd && !nb_in) || i_cmd.nb_eval) begin
                if (r_dr == 2'd2) begin
                    r_dr <= '0;
                    r_dc <= r_dc + 2'd1;
                end else begin
                    r_dr <= r_dr + 2'd1;
                end
            end
            // A placement from a seed or a previous-pass cell disarms the fallback at once.
            if (i_cmd.nb_eval && r_q == '0 && r_prog) r_mode <= gwdf_pkg::MODE_PROG;
            if (i_cmd.adv) begin
                if (col_last) begin
                    r_c <= '0;
                    r_r <= r_r + RW'(1);
                end else begin
                    r_c <= r_c + CW'(1);
                end
            end
            if (i_cmd.pass_end && r_empty) begin
                if (o_stat.at_limit) r_limit <= 1'b1;
                else r_n <= r_n + PW'(1);
            end
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.clr_last   = &r_clr;
        o_stat.grid_empty = (h_eff == '0) || (w_eff == '0);
        o_stat.grow       = is_seed || is_prev
                         || (is_block && r_mode == gwdf_pkg::MODE_ARMED && empty_now);
        o_stat.nb_in      = nb_in;
        o_stat.nb_last    = nb_last;
        o_stat.scan_end   = row_last && col_last;
        o_stat.empty_seen = r_empty;
        o_stat.at_limit   = r_n >= PW'(WEIGHT_LIMIT);
        o_stat.out_free   = !r_o_valid || !i_stall;
    end

    assign o_valid      = r_o_valid;
    assign o_cell_value = $signed(r_o_val);
    assign o_limit_hit  = r_o_lim;

    a_mode_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == gwdf_pkg::MODE_IDLE) || (r_mode == gwdf_pkg::MODE_PROG)
        || (r_mode == gwdf_pkg::MODE_ARMED))
        else $error("progress mode holds an unused code");

    a_limit_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_limit) |-> (r_n == PW'(WEIGHT_LIMIT)))
        else $error("limit flag set below the weight limit");

    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.done |=> r_o_valid)
        else $error("finished run produced no result");

endmodule

// ----- hw/rtl/grid_wavefront_distance_fill_top.sv -----
// Top level of the grid wavefront distance fill block.
// Write and unknown requests take one cycle and give their result one cycle after acceptance;
// a read stalls the input in the read-result state, which registers its result. A run makes
// up to WEIGHT_LIMIT passes of start, per-cell read, evaluate and advance, and end states,
// with a read per neighbour of a growing cell and a check per in-grid one; the done state
// registers the result. After reset a sweep zeroes all 2^(row bits + column bits) entries
// (4096 by default); requests are stalled until it ends, config writes are taken throughout.
module grid_wavefront_distance_fill_top #(
    parameter int MAX_COLS     = gwdf_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS     = gwdf_pkg::MAX_ROWS_DEF,
    parameter int WEIGHT_LIMIT = gwdf_pkg::WEIGHT_LIMIT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [gwdf_pkg::REQ_W-1:0]         i_req_type,
    input  logic [gwdf_pkg::IDX_W-1:0]         i_row,
    input  logic [gwdf_pkg::IDX_W-1:0]         i_col,
    input  logic [gwdf_pkg::CODE_W-1:0]        i_cell_code,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [gwdf_pkg::OUT_W-1:0]  o_cell_value,
    output logic                               o_limit_hit,
    input  logic                               i_cfg_we,
    input  logic                               i_cfg_index,
    input  logic [gwdf_pkg::GRID_W-1:0]        i_cfg_data
);

    gwdf_pkg::t_cmd  cmd;
    gwdf_pkg::t_stat stat;

    gwdf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gwdf_dpath #(
        .MAX_COLS     (MAX_COLS),
        .MAX_ROWS     (MAX_ROWS),
        .WEIGHT_LIMIT (WEIGHT_LIMIT)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_req_type   (i_req_type),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_cell_code  (i_cell_code),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cell_value (o_cell_value),
        .o_limit_hit  (o_limit_hit)
    );

endmodule

// ----- tb/tb_grid_wavefront_distance_fill_top.sv -----
// Self-checking testbench for the grid wavefront distance fill block.
`timescale 1ns / 100ps

module tb_grid_wavefront_distance_fill_top;

    typedef struct {
        logic signed [gwdf_pkg::OUT_W-1:0] value;
        logic                              limit;
    } t_fill_result;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic [gwdf_pkg::REQ_W-1:0]         i_req_type;
    logic [gwdf_pkg::IDX_W-1:0]         i_row;
    logic [gwdf_pkg::IDX_W-1:0]         i_col;
    logic [gwdf_pkg::CODE_W-1:0]        i_cell_code;
    logic                               o_valid;
    logic                               i_stall;
    logic signed [gwdf_pkg::OUT_W-1:0]  o_cell_value;
    logic                               o_limit_hit;
    logic                               i_cfg_we;
    logic                               i_cfg_index;
    logic [gwdf_pkg::GRID_W-1:0]        i_cfg_data;

    grid_wavefront_distance_fill_top dut (.*);

    // Predicted state of the block.
    int           grid_cells [gwdf_pkg::MAX_ROWS_DEF][gwdf_pkg::MAX_COLS_DEF];
    int           cols_in_use = 64;
    int           rows_in_use = 64;
    logic [1:0]   fill_mode = gwdf_pkg::MODE_PROG;
    bit           empty_found;
    bit           limit_reached;
    t_fill_result pending_results [$];

    int mismatches;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    bit hold_req;
    int quiet_cycles;
    int watch_limit = 20000;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit grow_around(int n, int r, int c, int w, int h);
        bit placed;
        int rr;
        int cc;
        placed = 1'b0;
        for (int dc = -1; dc <= 1; dc++) begin
            for (int dr = -1; dr <= 1; dr++) begin
                rr = r + dr;
                cc = c + dc;
                if (rr >= 0 && cc >= 0 && rr < h && cc < w && grid_cells[rr][cc] == 0) begin
                    grid_cells[rr][cc] = n;
                    placed = 1'b1;
                end
            end
        end
        return placed;
    endfunction

    function automatic void sweep_pass(int n, int w, int h);
        empty_found = 1'b0;
        for (int r = 0; r < h; r++) begin
            for (int c = 0; c < w; c++) begin
                if (grid_cells[r][c] == 0)
                    empty_found = 1'b1;
                if (grid_cells[r][c] == -1 && grow_around(n, r, c, w, h))
                    fill_mode = gwdf_pkg::MODE_PROG;
                if (n > 1 && grid_cells[r][c] == n - 1 && grow_around(n, r, c, w, h))
                    fill_mode = gwdf_pkg::MODE_PROG;
                if (grid_cells[r][c] == -2 && fill_mode == gwdf_pkg::MODE_ARMED && empty_found)
                    void'(grow_around(n, r, c, w, h));
                // The fallback overwrites the last cell whatever it holds.
                if (r == h - 1 && c == w - 1 && fill_mode == gwdf_pkg::MODE_ARMED && empty_found)
                    grid_cells[r][c] = n;
            end
        end
    endfunction

    function automatic void fill_distances();
        int n;
        int w;
        int h;
        w = (cols_in_use > gwdf_pkg::MAX_COLS_DEF) ? gwdf_pkg::MAX_COLS_DEF : cols_in_use;
        h = (rows_in_use > gwdf_pkg::MAX_ROWS_DEF) ? gwdf_pkg::MAX_ROWS_DEF : rows_in_use;
        n = 1;
        fill_mode = gwdf_pkg::MODE_PROG;
        limit_reached = 1'b0;
        while (1'b1) begin
            fill_mode = (fill_mode == gwdf_pkg::MODE_IDLE) ? gwdf_pkg::MODE_ARMED
                                                           : gwdf_pkg::MODE_IDLE;
            sweep_pass(n, w, h);
            if (!empty_found)
                break;
            if (n >= gwdf_pkg::WEIGHT_LIMIT_DEF) begin
                limit_reached = 1'b1;
                break;
            end
            n++;
        end
        watch_limit = 20000 + 100 * n * (w * h + 1);
    endfunction

    function automatic void predict_request(logic [gwdf_pkg::REQ_W-1:0] rq,
                                            logic [gwdf_pkg::IDX_W-1:0] r,
                                            logic [gwdf_pkg::IDX_W-1:0] c,
                                            logic [gwdf_pkg::CODE_W-1:0] code);
        t_fill_result res;
        res.value = '0;
        case (rq)
            gwdf_pkg::REQ_WRITE: begin
                if (code != gwdf_pkg::CODE_BAD)
                    grid_cells[r][c] = (code == gwdf_pkg::CODE_EMPTY) ? 0 :
                                       (code == gwdf_pkg::CODE_SEED ? -1 : -2);
            end
            gwdf_pkg::REQ_RUN: fill_distances();
            gwdf_pkg::REQ_READ: res.value = grid_cells[r][c][gwdf_pkg::OUT_W-1:0];
            default: ;
        endcase
        res.limit = limit_reached;
        pending_results.push_back(res);
    endfunction

    // Track configuration, accepted requests and results; check each result.
    always @(posedge i_clk) begin
        t_fill_result exp_res;
        quiet_cycles = quiet_cycles + 1;
        if (i_cfg_we) begin
            quiet_cycles = 0;
            if (i_cfg_index == gwdf_pkg::CFG_WIDTH)
                cols_in_use = int'(i_cfg_data);
            else
                rows_in_use = int'(i_cfg_data);
        end
        if (i_rst_n && i_valid && !o_stall) begin
            quiet_cycles = 0;
            predict_request(i_req_type, i_row, i_col, i_cell_code);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            quiet_cycles = 0;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result value=%0d limit=%0b", $time,
                         o_cell_value, o_limit_hit);
            end else begin
                exp_res = pending_results.pop_front();
                if (o_cell_value !== exp_res.value) begin
                    mismatches++;
                    $display("%0t: cell_value expected %0d actual %0d", $time,
                             exp_res.value, o_cell_value);
                end
                if (o_limit_hit !== exp_res.limit) begin
                    mismatches++;
                    $display("%0t: limit_hit expected %0b actual %0b", $time,
                             exp_res.limit, o_limit_hit);
                end
            end
        end
        if (quiet_cycles > watch_limit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_req(logic [gwdf_pkg::REQ_W-1:0] rq, int r, int c,
                            logic [gwdf_pkg::CODE_W-1:0] code);
        bit taken;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= rq;
        i_row       <= r[gwdf_pkg::IDX_W-1:0];
        i_col       <= c[gwdf_pkg::IDX_W-1:0];
        i_cell_code <= code;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_grid(int w, int h);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= gwdf_pkg::CFG_WIDTH;
        i_cfg_data  <= w[gwdf_pkg::GRID_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= gwdf_pkg::CFG_HEIGHT;
        i_cfg_data  <= h[gwdf_pkg::GRID_W-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic test_seed_fill();
        set_grid(4, 3);
        send_req(gwdf_pkg::REQ_WRITE, 1, 1, gwdf_pkg::CODE_SEED);
        send_req(gwdf_pkg::REQ_WRITE, 0, 3, gwdf_pkg::CODE_BLOCK);
        send_req(gwdf_pkg::REQ_RUN, 0, 0, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 0, 0, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 2, 3, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 0, 3, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 1, 1, gwdf_pkg::CODE_EMPTY);
    endtask

    // The old seed is cleared and one new seed set in the grid's corner, with a blocked cell, before the run.
    task automatic test_fallback();
        set_grid(3, 3);
        send_req(gwdf_pkg::REQ_WRITE, 1, 1, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_WRITE, 0, 3, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_WRITE, 1, 0, gwdf_pkg::CODE_BLOCK);
        send_req(gwdf_pkg::REQ_WRITE, 2, 2, gwdf_pkg::CODE_SEED);
        send_req(gwdf_pkg::REQ_RUN, 0, 0, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 2, 2, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 0, 0, gwdf_pkg::CODE_EMPTY);
    endtask

    // Zero and oversized grids, unknown codes and unknown requests.
    task automatic test_odd_requests();
        set_grid(0, 0);
        send_req(gwdf_pkg::REQ_RUN, 0, 0, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_WRITE, 63, 63, gwdf_pkg::CODE_BAD);
        send_req(gwdf_pkg::REQ_WRITE, 63, 0, gwdf_pkg::CODE_SEED);
        send_req(gwdf_pkg::REQ_UNKNOWN, 63, 63, gwdf_pkg::CODE_BAD);
        send_req(gwdf_pkg::REQ_READ, 63, 0, gwdf_pkg::CODE_BAD);
        set_grid(127, 1);
        send_req(gwdf_pkg::REQ_RUN, 0, 0, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 0, 63, gwdf_pkg::CODE_EMPTY);
        set_grid(1, 64);
        send_req(gwdf_pkg::REQ_RUN, 0, 0, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 63, 0, gwdf_pkg::CODE_EMPTY);
        send_req(gwdf_pkg::REQ_READ, 62, 0, gwdf_pkg::CODE_EMPTY);
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_idle_pct = 0;
        hold_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_req(gwdf_pkg::REQ_READ, $urandom_range(63), $urandom_range(63),
                     gwdf_pkg::CODE_W'($urandom_range(3)));
        wait_idle();
    endtask

    // A job on a random grid, mostly small: load cells, run, read back; some noise around it.
    task automatic random_job();
        int w;
        int h;
        int r;
        int c;
        int pick;
        logic [gwdf_pkg::CODE_W-1:0] code;
        if ($urandom_range(9) == 0) begin
            w = $urandom_range(127);
            h = $urandom_range(1);
        end else begin
            w = $urandom_range(8, 1);
            h = $urandom_range(8, 1);
        end
        if ($urandom_range(1))
            {w, h} = {h, w};
        set_grid(w, h);
        repeat ($urandom_range(10, 2)) begin
            r = (h == 0 || $urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(h - 1);
            c = (w == 0 || $urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(w - 1);
            if (r > 63) r = 63;
            if (c > 63) c = 63;
            pick = $urandom_range(99);
            code = (pick < 50) ? gwdf_pkg::CODE_EMPTY : (pick < 70) ? gwdf_pkg::CODE_SEED :
                   (pick < 95) ? gwdf_pkg::CODE_BLOCK : gwdf_pkg::CODE_BAD;
            send_req(gwdf_pkg::REQ_WRITE, r, c, code);
        end
        if ($urandom_range(4) == 0)
            send_req(gwdf_pkg::REQ_UNKNOWN, $urandom_range(63), $urandom_range(63),
                     gwdf_pkg::CODE_W'($urandom_range(3)));
        send_req(gwdf_pkg::REQ_RUN, $urandom_range(63), $urandom_range(63),
                 gwdf_pkg::CODE_W'($urandom_range(3)));
        repeat ($urandom_range(12, 4)) begin
            r = (h == 0 || $urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(h - 1);
            c = (w == 0 || $urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(w - 1);
            if (r > 63) r = 63;
            if (c > 63) c = 63;
            send_req(gwdf_pkg::REQ_READ, r, c, gwdf_pkg::CODE_W'($urandom_range(3)));
        end
    endtask

    task automatic test_random();
        int target;
        target = items_sent + 830;
        send_idle_pct = 16;
        recv_idle_pct = 76;
        while (items_sent < target - 553)
            random_job();
        send_idle_pct = 76;
        recv_idle_pct = 16;
        while (items_sent < target - 276)
            random_job();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        while (items_sent < target)
            random_job();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_req_type    = gwdf_pkg::REQ_WRITE;
        i_row         = '0;
        i_col         = '0;
        i_cell_code   = gwdf_pkg::CODE_EMPTY;
        i_stall       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = gwdf_pkg::CFG_WIDTH;
        i_cfg_data    = '0;
        send_idle_pct = 16;
        recv_idle_pct = 76;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_seed_fill();
        test_fallback();
        test_odd_requests();
        test_backpressure();
        send_idle_pct = 16;
        recv_idle_pct = 76;
        test_random();
        wait_idle();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/gwdf_pkg.sv
hw/rtl/gwdf_ctrl.sv
hw/rtl/gwdf_dpath.sv
hw/rtl/grid_wavefront_distance_fill_top.sv
tb/tb_grid_wavefront_distance_fill_top.sv
